// ----- rtl/acpu_pkg.sv -----
// Package for the accumulator processor core: sequencer state type,
// opcode, item kind and skip condition codes, and the default memory depth.
// Used by accumulator_cpu_core; depends on nothing.
`default_nettype none

package acpu_pkg;

  // Default depth of main memory in 16-bit words.
  localparam int MEM_DEPTH_DEFAULT = 4096;

  // Fixed widths of the item fields.
  localparam int WORD_W = 16;
  localparam int PC_W   = 12;

  // Kinds of input item.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_EXEC    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Instruction opcodes, held in bits 15:12 of an instruction word.
  localparam logic [3:0] OP_JNS      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_STORE    = 4'd2;
  localparam logic [3:0] OP_ADD      = 4'd3;
  localparam logic [3:0] OP_SUBT     = 4'd4;
  localparam logic [3:0] OP_INPUT    = 4'd5;
  localparam logic [3:0] OP_OUTPUT   = 4'd6;
  localparam logic [3:0] OP_HALT     = 4'd7;
  localparam logic [3:0] OP_SKIPCOND = 4'd8;
  localparam logic [3:0] OP_JUMP     = 4'd9;
  localparam logic [3:0] OP_CLEAR    = 4'd10;
  localparam logic [3:0] OP_ADDI     = 4'd11;
  localparam logic [3:0] OP_JUMPI    = 4'd12;

  // Skipcond selectors, held in bits 11:8.
  localparam logic [3:0] COND_NEG  = 4'd0;
  localparam logic [3:0] COND_ZERO = 4'd4;
  localparam logic [3:0] COND_POS  = 4'd8;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_DECODE,
    S_REDUCE,
    S_OPER,
    S_OPDATA,
    S_INDIR,
    S_INDDATA,
    S_LOADWR,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/accumulator_cpu_core.sv -----
// Accumulator processor core with main memory, sequencer and shared adder.
// Depends on acpu_pkg.
//
// Use: one input channel (in_valid / in_stall) takes items of three kinds:
// a load item writes load_word to memory at load_address, a step item runs
// one instruction (in_value feeds Input), and a restart item clears PC, AC
// and the halt state while memory is kept. Every item gives exactly one
// result on the result channel (res_valid / res_stall), which carries the
// instruction flags and the PC, AC and halt state after the item.
// Timing: the block takes one item at a time and holds in_stall high from
// acceptance until its result has been taken. A restart or a halted step
// goes straight to its result, a load writes memory and then gives its
// result, and a step runs fetch and decode, then operand read, operand
// data, indirect read and indirect data as the opcode needs. With a
// power-of-two depth an address wraps by masking; with any other depth
// each address wrap runs through the shared adder as a restoring
// reduction.
// Reset clears PC, AC, the halt state and the sequencer; memory contents
// are undefined until loaded. While the receiver stalls, the result and
// all state hold and no new item is taken.
`default_nettype none

module accumulator_cpu_core #(
  parameter int MEM_DEPTH = acpu_pkg::MEM_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input items
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [11:0]        load_address,
  input  wire logic [15:0]        load_word,
  input  wire logic signed [15:0] in_value,
  // Result items
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic                    out_valid,
  output logic signed [15:0]      out_value,
  output logic                    input_used,
  output logic                    halted_flag,
  output logic                    bad_opcode,
  output logic [11:0]             pc_now,
  output logic signed [15:0]      ac_now
);

  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam bit POW2   = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
  // Restoring reduction steps for a 16-bit value modulo the depth.
  localparam int KSTEPS = 17 - ADDR_W;
  localparam int K_W    = $clog2(KSTEPS);
  localparam logic [15:0] ADDR_MASK = 16'(MEM_DEPTH - 1);
  localparam logic [15:0] DEPTH_W   = 16'(MEM_DEPTH);
  localparam logic [ADDR_W-1:0] PC_LAST = ADDR_W'(MEM_DEPTH - 1);

  acpu_pkg::state_t state, state_next, ret;

  logic [ADDR_W-1:0] pc;
  logic [15:0]       ac;
  logic              halt;
  logic [15:0]       ir;
  logic [15:0]       red;
  logic [K_W-1:0]    red_k;
  logic [15:0]       load_word_q;
  logic [15:0]       in_value_q;

  // Memory port and its registered read data.
  logic [15:0]       mem [MEM_DEPTH];
  logic [15:0]       rdata;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [15:0]       mem_wdata;

  // Shared adder.
  logic [15:0] alu_a, alu_b;
  logic        alu_sub;
  logic [16:0] alu_sum;

  // Reduction start request.
  logic              red_start;
  logic [15:0]       red_val;
  acpu_pkg::state_t  red_ret;

  logic [ADDR_W-1:0] pc_inc;
  logic [3:0]        opcode;
  logic              accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != acpu_pkg::S_IDLE);
  assign res_valid = (state == acpu_pkg::S_RESULT);
  assign halted_flag = halt;
  assign pc_now    = 12'(pc);
  assign ac_now    = ac;
  assign pc_inc    = (pc == PC_LAST) ? '0 : pc + ADDR_W'(1);
  assign opcode    = ir[15:12];

  // One adder serves AC arithmetic and the address reduction; bit 16 is
  // the no-borrow flag when subtracting.
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 17'(alu_sub);

  // Main memory: one port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acpu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory control and adder operands.
  always_comb begin
    state_next = state;
    mem_addr   = pc;
    mem_we     = 1'b0;
    mem_wdata  = ac;
    alu_a      = ac;
    alu_b      = rdata;
    alu_sub    = 1'b0;
    red_start  = 1'b0;
    red_val    = rdata;
    red_ret    = acpu_pkg::S_RESULT;
    case (state)
      acpu_pkg::S_IDLE: begin
        if (in_valid) begin
          case (kind)
            acpu_pkg::KIND_LOAD: begin
              red_start = 1'b1;
              red_val   = {4'b0, load_address};
              red_ret   = acpu_pkg::S_LOADWR;
            end
            acpu_pkg::KIND_EXEC: begin
              state_next = halt ? acpu_pkg::S_RESULT : acpu_pkg::S_FETCH;
            end
            default: begin
              state_next = acpu_pkg::S_RESULT;
            end
          endcase
        end
      end
      acpu_pkg::S_FETCH: begin
        mem_addr   = pc;
        state_next = acpu_pkg::S_DECODE;
      end
      acpu_pkg::S_DECODE: begin
        case (rdata[15:12])
          acpu_pkg::OP_LOAD, acpu_pkg::OP_STORE, acpu_pkg::OP_ADD,
          acpu_pkg::OP_SUBT, acpu_pkg::OP_JUMP, acpu_pkg::OP_ADDI,
          acpu_pkg::OP_JUMPI: begin
            red_start = 1'b1;
            red_val   = {4'b0, rdata[11:0]};
            red_ret   = acpu_pkg::S_OPER;
          end
          default: begin
            state_next = acpu_pkg::S_RESULT;
          end
        endcase
      end
      acpu_pkg::S_REDUCE: begin
        alu_a   = red;
        alu_b   = DEPTH_W << red_k;
        alu_sub = 1'b1;
        if (red_k == '0) begin
          state_next = ret;
        end
      end
      acpu_pkg::S_OPER: begin
        mem_addr = red[ADDR_W-1:0];
        case (opcode)
          acpu_pkg::OP_JUMP: begin
            state_next = acpu_pkg::S_RESULT;
          end
          acpu_pkg::OP_STORE: begin
            mem_we     = 1'b1;
            mem_wdata  = ac;
            state_next = acpu_pkg::S_RESULT;
          end
          default: begin
            state_next = acpu_pkg::S_OPDATA;
          end
        endcase
      end
      acpu_pkg::S_OPDATA: begin
        alu_a   = ac;
        alu_b   = rdata;
        alu_sub = (opcode == acpu_pkg::OP_SUBT);
        if (opcode == acpu_pkg::OP_ADDI || opcode == acpu_pkg::OP_JUMPI) begin
          red_start = 1'b1;
          red_val   = rdata;
          red_ret   = acpu_pkg::S_INDIR;
        end else begin
          state_next = acpu_pkg::S_RESULT;
        end
      end
      acpu_pkg::S_INDIR: begin
        mem_addr = red[ADDR_W-1:0];
        state_next = (opcode == acpu_pkg::OP_ADDI) ? acpu_pkg::S_INDDATA
                                                   : acpu_pkg::S_RESULT;
      end
      acpu_pkg::S_INDDATA: begin
        alu_a      = ac;
        alu_b      = rdata;
        state_next = acpu_pkg::S_RESULT;
      end
      acpu_pkg::S_LOADWR: begin
        mem_addr   = red[ADDR_W-1:0];
        mem_we     = 1'b1;
        mem_wdata  = load_word_q;
        state_next = acpu_pkg::S_RESULT;
      end
      acpu_pkg::S_RESULT: begin
        if (!res_stall) begin
          state_next = acpu_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = acpu_pkg::S_IDLE;
      end
    endcase
    // A power-of-two depth wraps by masking, so the reduction is skipped.
    if (red_start) begin
      state_next = POW2 ? red_ret : acpu_pkg::S_REDUCE;
    end
  end

  // Architectural registers and result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      ac         <= '0;
      halt       <= 1'b0;
      out_valid  <= 1'b0;
      out_value  <= '0;
      input_used <= 1'b0;
      bad_opcode <= 1'b0;
    end else begin
      // Start a reduction of an address value.
      if (red_start) begin
        red   <= POW2 ? (red_val & ADDR_MASK) : red_val;
        red_k <= K_W'(KSTEPS - 1);
        ret   <= red_ret;
      end
      case (state)
        acpu_pkg::S_IDLE: begin
          if (accept) begin
            load_word_q <= load_word;
            in_value_q  <= in_value;
            out_valid   <= 1'b0;
            out_value   <= '0;
            input_used  <= 1'b0;
            bad_opcode  <= 1'b0;
            if (kind == acpu_pkg::KIND_RESTART) begin
              pc   <= '0;
              ac   <= '0;
              halt <= 1'b0;
            end
          end
        end
        acpu_pkg::S_FETCH: begin
          pc <= pc_inc;
        end
        acpu_pkg::S_DECODE: begin
          ir <= rdata;
          case (rdata[15:12])
            acpu_pkg::OP_INPUT: begin
              ac         <= in_value_q;
              input_used <= 1'b1;
            end
            acpu_pkg::OP_OUTPUT: begin
              out_valid <= 1'b1;
              out_value <= ac;
            end
            acpu_pkg::OP_HALT: begin
              halt <= 1'b1;
            end
            acpu_pkg::OP_CLEAR: begin
              ac <= '0;
            end
            acpu_pkg::OP_SKIPCOND: begin
              if ((rdata[11:8] == acpu_pkg::COND_NEG && ac[15]) ||
                  (rdata[11:8] == acpu_pkg::COND_ZERO && ac == '0) ||
                  (rdata[11:8] == acpu_pkg::COND_POS && !ac[15] && ac != '0)) begin
                pc <= pc_inc;
              end
            end
            acpu_pkg::OP_JNS, acpu_pkg::OP_LOAD, acpu_pkg::OP_STORE,
            acpu_pkg::OP_ADD, acpu_pkg::OP_SUBT, acpu_pkg::OP_JUMP,
            acpu_pkg::OP_ADDI, acpu_pkg::OP_JUMPI: begin
            end
            default: begin
              bad_opcode <= 1'b1;
            end
          endcase
        end
        acpu_pkg::S_REDUCE: begin
          // Restoring step: subtract the shifted depth where it fits.
          if (alu_sum[16]) begin
            red <= alu_sum[15:0];
          end
          red_k <= red_k - K_W'(1);
        end
        acpu_pkg::S_OPER: begin
          if (opcode == acpu_pkg::OP_JUMP) begin
            pc <= red[ADDR_W-1:0];
          end
        end
        acpu_pkg::S_OPDATA: begin
          if (opcode == acpu_pkg::OP_LOAD) begin
            ac <= rdata;
          end else if (opcode == acpu_pkg::OP_ADD || opcode == acpu_pkg::OP_SUBT) begin
            ac <= alu_sum[15:0];
          end
        end
        acpu_pkg::S_INDIR: begin
          if (opcode == acpu_pkg::OP_JUMPI) begin
            pc <= red[ADDR_W-1:0];
          end
        end
        acpu_pkg::S_INDDATA: begin
          ac <= alu_sum[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A restart item leaves PC, AC and the halt state clear.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && kind == acpu_pkg::KIND_RESTART |=> pc == '0 && ac == '0 && !halt)
    else $error("restart did not clear the core state");

  // The last reduction step leaves an address inside the memory.
  a_reduce_in_range: assert property (@(posedge clk) disable iff (rst)
    state == acpu_pkg::S_REDUCE && red_k == '0 |=> red < DEPTH_W)
    else $error("address reduction left a value beyond the depth");

  // One instruction sets at most one of the Output, Input and bad flags.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $countones({out_valid, input_used, bad_opcode}) <= 1)
    else $error("more than one instruction flag set in a result");

  // A stalled result keeps the architectural state unchanged.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(ac) && $stable(pc) && $stable(halt))
    else $error("core state changed while the result was stalled");

  // No item is taken while a result is being offered.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("item accepted while a result was pending");

endmodule

`default_nettype wire

// ----- bench/tb_accumulator_cpu_core.sv -----
// Self-checking testbench for accumulator_cpu_core: a scoreboard class mirrors
// the core's memory, PC, AC and halt state and checks every result item.
// Depends on acpu_pkg and the accumulator_cpu_core RTL.
`timescale 1ns / 100ps

localparam int CORE_DEPTH = acpu_pkg::MEM_DEPTH_DEFAULT;

// The one kind code that the package leaves unnamed; the core ignores it.
localparam logic [1:0] KIND_UNUSED = 2'd3;

// Opcodes with no instruction behind them.
localparam logic [3:0] OP_UNDEF_FIRST = 4'd13;
localparam logic [3:0] OP_UNDEF_LAST  = 4'd15;

// One result item as the core presents it.
typedef struct packed {
  logic        out_valid;
  logic [15:0] out_value;
  logic        input_used;
  logic        halted;
  logic        bad_op;
  logic [11:0] pc;
  logic [15:0] ac;
} core_result_t;

class acpu_scoreboard;
  logic [15:0]  mem [CORE_DEPTH];
  bit           written [CORE_DEPTH];
  logic [11:0]  pc;
  logic [15:0]  ac;
  bit           halted;
  core_result_t due_results [$];
  int           errors;

  function new();
    pc = '0;
    ac = '0;
    halted = 1'b0;
    errors = 0;
    foreach (written[i]) written[i] = 1'b0;
  endfunction

  function logic [11:0] wrap(int unsigned a);
    return 12'(a % CORE_DEPTH);
  endfunction

  // Applies one accepted item to the mirrored machine and queues its result.
  function void run_item(logic [1:0] k, logic [11:0] a, logic [15:0] w, logic [15:0] v);
    core_result_t r;
    logic [15:0]  ir;
    logic [11:0]  ea;
    logic [3:0]   sel;
    bit           skip;
    r = '0;
    case (k)
      acpu_pkg::KIND_LOAD: begin
        mem[wrap(a)] = w;
        written[wrap(a)] = 1'b1;
      end
      acpu_pkg::KIND_RESTART: begin
        pc = '0;
        ac = '0;
        halted = 1'b0;
      end
      acpu_pkg::KIND_EXEC: begin
        // A halted core fetches nothing.
        if (!halted) begin
          ir = mem[pc];
          sel = ir[11:8];
          ea = wrap(ir[11:0]);
          pc = wrap(pc + 1);
          case (ir[15:12])
            acpu_pkg::OP_JNS: ;
            acpu_pkg::OP_LOAD: ac = mem[ea];
            acpu_pkg::OP_STORE: begin
              mem[ea] = ac;
              written[ea] = 1'b1;
            end
            acpu_pkg::OP_ADD: ac = ac + mem[ea];
            acpu_pkg::OP_SUBT: ac = ac - mem[ea];
            acpu_pkg::OP_INPUT: begin
              ac = v;
              r.input_used = 1'b1;
            end
            acpu_pkg::OP_OUTPUT: begin
              r.out_valid = 1'b1;
              r.out_value = ac;
            end
            acpu_pkg::OP_HALT: halted = 1'b1;
            acpu_pkg::OP_SKIPCOND: begin
              case (sel)
                acpu_pkg::COND_NEG:  skip = ac[15];
                acpu_pkg::COND_ZERO: skip = (ac == 16'h0000);
                acpu_pkg::COND_POS:  skip = !ac[15] && ac != 16'h0000;
                default:   skip = 1'b0;
              endcase
              if (skip) pc = wrap(pc + 1);
            end
            acpu_pkg::OP_JUMP: pc = ea;
            acpu_pkg::OP_CLEAR: ac = '0;
            acpu_pkg::OP_ADDI: ac = ac + mem[wrap(mem[ea])];
            acpu_pkg::OP_JUMPI: pc = wrap(mem[ea]);
            default: r.bad_op = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    r.halted = halted;
    r.pc = pc;
    r.ac = ac;
    due_results.push_back(r);
  endfunction

  function void compare(string field, logic [15:0] want, logic [15:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= 100) $display("%0t: %s expected %h, got %h", $time, field, want, seen);
    end
  endfunction

  // Checks one result item against the oldest outstanding expectation.
  function void check_result(core_result_t got);
    core_result_t want;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 100)
        $display("%0t: result item with none outstanding: pc %h ac %h", $time, got.pc, got.ac);
      return;
    end
    want = due_results.pop_front();
    compare("out_valid", want.out_valid, got.out_valid);
    compare("out_value", want.out_value, got.out_value);
    compare("input_used", want.input_used, got.input_used);
    compare("halted_flag", want.halted, got.halted);
    compare("bad_opcode", want.bad_op, got.bad_op);
    compare("pc_now", want.pc, got.pc);
    compare("ac_now", want.ac, got.ac);
  endfunction
endclass

module tb_accumulator_cpu_core;

  localparam int RUN_ITEMS   = 1530;
  localparam int QUIET_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic [11:0]        load_address;
  logic [15:0]        load_word;
  logic signed [15:0] in_value;
  logic               res_valid;
  logic               res_stall;
  logic               out_valid;
  logic signed [15:0] out_value;
  logic               input_used;
  logic               halted_flag;
  logic               bad_opcode;
  logic [11:0]        pc_now;
  logic signed [15:0] ac_now;

  acpu_scoreboard sb;
  int             items_accepted = 0;
  int             quiet_cycles = 0;
  bit             calm = 1'b0;

  accumulator_cpu_core dut (.*);

  always #5 clk = ~clk;

  // Mostly random words, with the extremes mixed in.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Addresses cluster low so that programs reuse their words.
  function automatic logic [11:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return 12'($urandom_range(63));
    if (r < 95) return 12'($urandom);
    return r[0] ? 12'hFFF : 12'h000;
  endfunction

  // Offers one item and holds it until the core takes it, then mirrors it.
  task automatic send_item(input logic [1:0] k, input logic [11:0] a, input logic [15:0] w,
                           input logic [15:0] v);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < 27) ? $urandom_range(3, 1) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    load_address <= a;
    load_word <= w;
    in_value <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.run_item(k, a, w, v);
    items_accepted++;
  endtask

  // Before a step, makes sure that every word the instruction at PC reads has
  // been loaded; otherwise, and now and then anyway, plants a new instruction.
  task automatic prepare_step();
    logic [15:0] ir;
    logic [11:0] here, ea, ptr, operand;
    logic [3:0]  op;
    bit          safe;
    int unsigned r;
    here = sb.pc;
    ir = sb.mem[here];
    ea = ir[11:0];
    safe = sb.written[here];
    if (safe) begin
      case (ir[15:12])
        acpu_pkg::OP_LOAD, acpu_pkg::OP_ADD, acpu_pkg::OP_SUBT,
        acpu_pkg::OP_JUMPI: safe = sb.written[ea];
        acpu_pkg::OP_ADDI: safe = sb.written[ea] && sb.written[sb.mem[ea][11:0]];
        default: ;
      endcase
    end
    if (safe && $urandom_range(99) >= 30) return;

    r = $urandom_range(99);
    if (r < 8) op = acpu_pkg::OP_LOAD;
    else if (r < 14) op = acpu_pkg::OP_STORE;
    else if (r < 26) op = acpu_pkg::OP_ADD;
    else if (r < 34) op = acpu_pkg::OP_SUBT;
    else if (r < 42) op = acpu_pkg::OP_INPUT;
    else if (r < 52) op = acpu_pkg::OP_OUTPUT;
    else if (r < 55) op = acpu_pkg::OP_HALT;
    else if (r < 70) op = acpu_pkg::OP_SKIPCOND;
    else if (r < 77) op = acpu_pkg::OP_JUMP;
    else if (r < 81) op = acpu_pkg::OP_CLEAR;
    else if (r < 88) op = acpu_pkg::OP_ADDI;
    else if (r < 93) op = acpu_pkg::OP_JUMPI;
    else if (r < 96) op = acpu_pkg::OP_JNS;
    else op = 4'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));

    operand = 12'($urandom);
    case (op)
      acpu_pkg::OP_LOAD, acpu_pkg::OP_ADD, acpu_pkg::OP_SUBT, acpu_pkg::OP_ADDI,
      acpu_pkg::OP_JUMPI: begin
        do ea = pick_address(); while (ea == here);
        operand = ea;
        if (op == acpu_pkg::OP_ADDI || op == acpu_pkg::OP_JUMPI) begin
          // Fresh pointer, or reuse whatever the operand word already holds.
          if (!sb.written[ea] || $urandom_range(1) == 0) begin
            ptr = pick_address();
            if (op == acpu_pkg::OP_ADDI && !sb.written[ptr] && ptr != here && ptr != ea)
              send_item(acpu_pkg::KIND_LOAD, ptr, pick_word(), pick_word());
            send_item(acpu_pkg::KIND_LOAD, ea, {4'($urandom), ptr}, pick_word());
          end else if (op == acpu_pkg::OP_ADDI) begin
            ptr = sb.mem[ea][11:0];
            if (!sb.written[ptr] && ptr != here)
              send_item(acpu_pkg::KIND_LOAD, ptr, pick_word(), pick_word());
          end
        end else if (!sb.written[ea] || $urandom_range(3) == 0) begin
          send_item(acpu_pkg::KIND_LOAD, ea, pick_word(), pick_word());
        end
      end
      acpu_pkg::OP_SKIPCOND: begin
        case ($urandom_range(4))
          0: operand[11:8] = acpu_pkg::COND_NEG;
          1: operand[11:8] = acpu_pkg::COND_ZERO;
          2: operand[11:8] = acpu_pkg::COND_POS;
          default: ;
        endcase
      end
      acpu_pkg::OP_JUMP, acpu_pkg::OP_STORE: operand = pick_address();
      default: ;
    endcase
    send_item(acpu_pkg::KIND_LOAD, here, {op, operand}, pick_word());
  endtask

  // Result side: check every accepted result item.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0)
      sb.check_result({out_valid, out_value, input_used, halted_flag, bad_opcode,
                       pc_now, ac_now});
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("accumulator_cpu_core: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off to back the core up, and a
  // calm stretch with no stalls at all.
  initial begin
    bit held;
    held = 1'b0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_accepted >= 300) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (200) @(negedge clk);
      end
      res_stall <= !calm && ($urandom_range(99) < 27);
    end
  end

  // Sender: reset, a short directed program, then random items.
  initial begin
    int unsigned r;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    kind = acpu_pkg::KIND_LOAD;
    load_address = '0;
    load_word = '0;
    in_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed program: runs every instruction once, with a taken negative
    // skip, an indirect pointer whose high bits must be dropped, an undefined
    // opcode, and a halt at the top word so that the PC wraps to zero.
    send_item(acpu_pkg::KIND_LOAD, 12'hFFF, {acpu_pkg::OP_HALT, 12'hFFF}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h000, {acpu_pkg::OP_INPUT, 12'h000}, 16'hFFFF);
    send_item(acpu_pkg::KIND_LOAD, 12'h001, {acpu_pkg::OP_SKIPCOND, acpu_pkg::COND_NEG, 8'h00},
              16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h003, {acpu_pkg::OP_ADD, 12'hFFF}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h004, {acpu_pkg::OP_ADDI, 12'h003}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h005, {acpu_pkg::OP_SUBT, 12'h000}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h006, {acpu_pkg::OP_STORE, 12'h002}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h007, {acpu_pkg::OP_CLEAR, 12'h000}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h008, {acpu_pkg::OP_LOAD, 12'h002}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h009, {acpu_pkg::OP_OUTPUT, 12'h000}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h00A, {acpu_pkg::OP_JNS, 12'hFFF}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h00B, {OP_UNDEF_LAST, 12'h000}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h00C, {acpu_pkg::OP_JUMP, 12'h00E}, 16'h0000);
    send_item(acpu_pkg::KIND_LOAD, 12'h00E, {acpu_pkg::OP_JUMPI, 12'h003}, 16'h0000);
    send_item(acpu_pkg::KIND_EXEC, 12'hFFF, 16'hFFFF, 16'h8000);
    repeat (13) send_item(acpu_pkg::KIND_EXEC, 12'($urandom), pick_word(), pick_word());
    // Now halted: a step changes nothing, the unused kind is ignored.
    send_item(acpu_pkg::KIND_EXEC, 12'($urandom), pick_word(), 16'h7FFF);
    send_item(KIND_UNUSED, 12'($urandom), pick_word(), pick_word());
    send_item(acpu_pkg::KIND_RESTART, 12'($urandom), pick_word(), pick_word());

    // Random part: mostly running programs, with restarts and stray loads.
    while (items_accepted < RUN_ITEMS) begin
      calm = items_accepted >= 700 && items_accepted < 900;
      r = $urandom_range(99);
      if (sb.halted) begin
        if (r < 60)
          send_item(acpu_pkg::KIND_RESTART, 12'($urandom), pick_word(), pick_word());
        else if (r < 85)
          send_item(acpu_pkg::KIND_EXEC, 12'($urandom), pick_word(), pick_word());
        else
          send_item(acpu_pkg::KIND_LOAD, 12'($urandom), pick_word(), pick_word());
      end else if (r < 3) begin
        send_item(acpu_pkg::KIND_RESTART, 12'($urandom), pick_word(), pick_word());
      end else if (r < 4) begin
        send_item(KIND_UNUSED, 12'($urandom), pick_word(), pick_word());
      end else if (r < 9) begin
        send_item(acpu_pkg::KIND_LOAD, 12'($urandom), pick_word(), pick_word());
      end else begin
        prepare_step();
        send_item(acpu_pkg::KIND_EXEC, 12'($urandom), pick_word(), pick_word());
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow a few more cycles.
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("accumulator_cpu_core: match");
    else
      $display("accumulator_cpu_core: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/acpu_pkg.sv
rtl/accumulator_cpu_core.sv
bench/tb_accumulator_cpu_core.sv
